FILE: src/hsvct_pkg.sv
// Package for the HSV color threshold pixel block: register indexes, reset values
// and fixed-point constants. It depends on nothing else.
package hsvct_pkg;

	localparam int unsigned CH_W     = 8;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned HSV_SH   = 12;
	localparam int unsigned GRAY_SH  = 14;
	localparam int unsigned SFAC_W   = 20;
	localparam int unsigned HFAC_W   = 17;
	localparam int unsigned HNUM_W   = 12;
	localparam int unsigned GACC_W   = 22;
	localparam int unsigned LAT      = 4;

	localparam int unsigned S_SCALE  = 255;
	localparam int unsigned H_SCALE  = 180;

	localparam logic [12:0] COEF_B   = 13'd1868;
	localparam logic [13:0] COEF_G   = 14'd9617;
	localparam logic [12:0] COEF_R   = 13'd4899;

	typedef enum logic [IDX_W-1:0] {
		REG_HUE_LOW  = 3'd0,
		REG_HUE_HIGH = 3'd1,
		REG_SAT_LOW  = 3'd2,
		REG_SAT_HIGH = 3'd3,
		REG_VAL_LOW  = 3'd4,
		REG_VAL_HIGH = 3'd5,
		REG_GRAY_THR = 3'd6
	} reg_idx_t;

	localparam logic [CH_W-1:0] RST_HUE_LOW  = 8'd0;
	localparam logic [CH_W-1:0] RST_HUE_HIGH = 8'd180;
	localparam logic [CH_W-1:0] RST_SAT_LOW  = 8'd0;
	localparam logic [CH_W-1:0] RST_SAT_HIGH = 8'd255;
	localparam logic [CH_W-1:0] RST_VAL_LOW  = 8'd0;
	localparam logic [CH_W-1:0] RST_VAL_HIGH = 8'd255;
	localparam logic [CH_W-1:0] RST_GRAY_THR = 8'd100;

endpackage

FILE: src/hsv_color_threshold_pixel.sv
// Top level of the HSV color threshold pixel block: BGR to HSV, range mask, gray and
// binary threshold in a four-stage pipeline. Depends on hsvct_pkg.
// The block takes one pixel word per cycle sustained.
// The four stages are extrema and gray sum, reciprocal table lookup, multiply, and
// rounding with bounds compare. busy is always low; the receiver cannot stall.
// Reset clears the stage valid bits and loads the register defaults.
module hsv_color_threshold_pixel (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [hsvct_pkg::CH_W-1:0]  blue,
	input  logic [hsvct_pkg::CH_W-1:0]  green,
	input  logic [hsvct_pkg::CH_W-1:0]  red,
	input  logic                        cfg_we,
	input  logic [hsvct_pkg::IDX_W-1:0] cfg_index,
	input  logic [hsvct_pkg::CH_W-1:0]  cfg_data,
	output logic                        done,
	output logic                        in_range,
	output logic [hsvct_pkg::CH_W-1:0]  gray_level,
	output logic                        foreground
);
	import hsvct_pkg::*;

	logic [CH_W-1:0] hue_low_q, hue_high_q, sat_low_q, sat_high_q;
	logic [CH_W-1:0] val_low_q, val_high_q, gray_thr_q;

	logic [SFAC_W-1:0] sfac_tab [256];
	logic [HFAC_W-1:0] hfac_tab [256];

	logic                     vld_s1, vld_s2, vld_s3, vld_s4;
	logic [CH_W-1:0]          v_s1, diff_s1, gray_s1;
	logic signed [HNUM_W-1:0] hnum_s1;
	logic [CH_W-1:0]          v_s2, diff_s2, gray_s2;
	logic signed [HNUM_W-1:0] hnum_s2;
	logic [SFAC_W-1:0]        sfac_s2;
	logic [HFAC_W-1:0]        hfac_s2;
	logic [CH_W-1:0]          v_s3, gray_s3;
	logic [SFAC_W+CH_W-1:0]   sprod_s3;
	logic signed [HNUM_W+HFAC_W:0] hprod_s3;
	logic                     rng_s4, fg_s4;
	logic [CH_W-1:0]          gray_s4;

	logic [CH_W-1:0]          vmax, vmin, diff;
	logic signed [HNUM_W-1:0] hnum;
	logic [GACC_W-1:0]        gacc;
	logic [SFAC_W+CH_W:0]     s_sum;
	logic [CH_W:0]            s_val;
	logic signed [HNUM_W+HFAC_W+1:0] h_sum, h_sh;
	logic signed [9:0]        h_raw, h_fix;
	logic                     ok;

	assign busy = 1'b0;

	// reciprocal tables, rounded at elaboration
	assign sfac_tab[0] = '0;
	assign hfac_tab[0] = '0;
	for (genvar i = 1; i < 256; i++) begin : g_tab
		localparam int unsigned SF = (2 * (S_SCALE << HSV_SH) + i) / (2 * i);
		localparam int unsigned HF = (2 * (H_SCALE << HSV_SH) + 6 * i) / (12 * i);
		assign sfac_tab[i] = SF[SFAC_W-1:0];
		assign hfac_tab[i] = HF[HFAC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_low_q  <= RST_HUE_LOW;
			hue_high_q <= RST_HUE_HIGH;
			sat_low_q  <= RST_SAT_LOW;
			sat_high_q <= RST_SAT_HIGH;
			val_low_q  <= RST_VAL_LOW;
			val_high_q <= RST_VAL_HIGH;
			gray_thr_q <= RST_GRAY_THR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HUE_LOW:  hue_low_q  <= cfg_data;
				REG_HUE_HIGH: hue_high_q <= cfg_data;
				REG_SAT_LOW:  sat_low_q  <= cfg_data;
				REG_SAT_HIGH: sat_high_q <= cfg_data;
				REG_VAL_LOW:  val_low_q  <= cfg_data;
				REG_VAL_HIGH: val_high_q <= cfg_data;
				REG_GRAY_THR: gray_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: extrema, hue sector numerator, gray sum
	always_comb begin
		vmax = blue;
		vmin = blue;
		if (green > vmax) vmax = green;
		if (red > vmax)   vmax = red;
		if (green < vmin) vmin = green;
		if (red < vmin)   vmin = red;
		diff = vmax - vmin;
		if (vmax == red)
			hnum = $signed({4'b0, green}) - $signed({4'b0, blue});
		else if (vmax == green)
			hnum = $signed({4'b0, blue}) - $signed({4'b0, red}) + $signed({3'b0, diff, 1'b0});
		else
			hnum = $signed({4'b0, red}) - $signed({4'b0, green}) + $signed({2'b0, diff, 2'b0});
		gacc = GACC_W'(COEF_B * blue) + GACC_W'(COEF_G * green) + GACC_W'(COEF_R * red)
			+ GACC_W'(1 << (GRAY_SH - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		v_s1    <= vmax;
		diff_s1 <= diff;
		hnum_s1 <= hnum;
		gray_s1 <= gacc[GRAY_SH +: CH_W];
		// stage 2: table lookup
		v_s2    <= v_s1;
		diff_s2 <= diff_s1;
		hnum_s2 <= hnum_s1;
		gray_s2 <= gray_s1;
		sfac_s2 <= sfac_tab[v_s1];
		hfac_s2 <= hfac_tab[diff_s1];
		// stage 3: multiply
		v_s3     <= v_s2;
		gray_s3  <= gray_s2;
		sprod_s3 <= diff_s2 * sfac_s2;
		hprod_s3 <= hnum_s2 * $signed({1'b0, hfac_s2});
	end

	// stage 4: round, wrap hue, compare
	always_comb begin
		s_sum = {1'b0, sprod_s3} + (SFAC_W+CH_W+1)'(1 << (HSV_SH - 1));
		s_val = s_sum[HSV_SH +: CH_W+1];
		h_sum = hprod_s3 + $signed((HNUM_W+HFAC_W+2)'(1 << (HSV_SH - 1)));
		h_sh  = h_sum >>> HSV_SH;
		h_raw = h_sh[9:0];
		h_fix = h_raw[9] ? h_raw + 10'sd180 : h_raw;
		ok = (h_fix[8:0] >= {1'b0, hue_low_q}) && (h_fix[8:0] <= {1'b0, hue_high_q})
			&& (s_val >= {1'b0, sat_low_q}) && (s_val <= {1'b0, sat_high_q})
			&& (v_s3 >= val_low_q) && (v_s3 <= val_high_q);
	end

	always_ff @(posedge clk) begin
		rng_s4  <= ok;
		gray_s4 <= ok ? gray_s3 : '0;
		fg_s4   <= ok && (gray_s3 > gray_thr_q);
	end

	assign done       = vld_s4;
	assign in_range   = rng_s4;
	assign gray_level = gray_s4;
	assign foreground = fg_s4;

	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("done without a start word four cycles before");
	a_fg_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done && foreground |-> in_range)
		else $error("foreground set on an out-of-range word");
	a_gray_mask: assert property (@(posedge clk) disable iff (!arst_n)
		done && !in_range |-> gray_level == '0)
		else $error("gray not cleared on an out-of-range word");
	a_fg_thr: assert property (@(posedge clk) disable iff (!arst_n)
		done && foreground |-> gray_level > gray_thr_q)
		else $error("foreground with gray at or below threshold");

endmodule
